[design/pft_pkg.sv]
// Shared types, codes and character classification for the format string tokenizer.
package pft_pkg;

  localparam int COUNT_BITS_DEF = 16;
  localparam int FIFO_DEPTH     = 4;
  localparam int OUT_NUM_BITS   = 16;
  localparam int OUT_TDATA_W    = 64;

  typedef enum logic [2:0] {
    KIND_TEXT    = 3'd0,
    KIND_INT     = 3'd1,
    KIND_FLOAT   = 3'd2,
    KIND_CHAR    = 3'd3,
    KIND_STRING  = 3'd4,
    KIND_POINTER = 3'd5,
    KIND_SCANSET = 3'd6,
    KIND_ERROR   = 3'd7
  } kind_t;

  typedef enum logic [2:0] {
    BASE_NONE = 3'd0,
    BASE_SDEC = 3'd1,
    BASE_UOCT = 3'd2,
    BASE_UDEC = 3'd3,
    BASE_UHEX = 3'd4
  } base_t;

  typedef enum logic [2:0] {
    LEN_NONE = 3'd0,
    LEN_H    = 3'd1,
    LEN_HH   = 3'd2,
    LEN_L    = 3'd3,
    LEN_LL   = 3'd4,
    LEN_BIGL = 3'd5,
    LEN_J    = 3'd6,
    LEN_T    = 3'd7
  } len_t;

  typedef enum logic [1:0] {
    ERR_NONE       = 2'd0,
    ERR_BAD_LETTER = 2'd1,
    ERR_END_SPEC   = 2'd2,
    ERR_END_SET    = 2'd3
  } err_t;

  localparam int FLAG_ALT   = 0;
  localparam int FLAG_ZERO  = 1;
  localparam int FLAG_LEFT  = 2;
  localparam int FLAG_SPACE = 3;
  localparam int FLAG_PLUS  = 4;
  localparam int FLAG_STAR  = 5;

  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_LBRK  = 8'h5B;
  localparam logic [7:0] CH_CARET = 8'h5E;
  localparam logic [7:0] CH_RBRK  = 8'h5D;
  localparam logic [7:0] CH_LOW_H = 8'h68;
  localparam logic [7:0] CH_LOW_L = 8'h6C;
  localparam logic [7:0] CH_UP_L  = 8'h4C;
  localparam logic [7:0] CH_LOW_J = 8'h6A;
  localparam logic [7:0] CH_LOW_T = 8'h74;

  // One classified input byte as it travels from the front to the back.
  typedef struct packed {
    logic [7:0] chr;
    logic       last;
    logic       is_digit;
    logic [3:0] digit;
    logic [4:0] flag_mask;
    logic       conv_ok;
    kind_t      conv_kind;
    base_t      conv_base;
  } byte_info_t;

  // One result item.
  typedef struct packed {
    kind_t                   kind;
    base_t                   base;
    logic [5:0]              flags;
    logic [OUT_NUM_BITS-1:0] fw;
    logic [OUT_NUM_BITS-1:0] prec;
    len_t                    len;
    logic [7:0]              text_char;
    logic                    new_run;
    err_t                    err;
    logic                    ends;
  } result_t;

  function automatic byte_info_t classify(input logic [7:0] c, input logic last);
    byte_info_t info;
    info.chr       = c;
    info.last      = last;
    info.is_digit  = (c >= CH_ZERO) && (c <= CH_NINE);
    info.digit     = 4'(c - CH_ZERO);
    info.flag_mask = '0;
    info.conv_ok   = 1'b1;
    info.conv_kind = KIND_ERROR;
    info.conv_base = BASE_NONE;
    case (c)
      CH_HASH:  info.flag_mask[FLAG_ALT]   = 1'b1;
      CH_ZERO:  info.flag_mask[FLAG_ZERO]  = 1'b1;
      CH_MINUS: info.flag_mask[FLAG_LEFT]  = 1'b1;
      CH_SPACE: info.flag_mask[FLAG_SPACE] = 1'b1;
      CH_PLUS:  info.flag_mask[FLAG_PLUS]  = 1'b1;
      default: ;
    endcase
    case (c) inside
      "d", "i":                               begin
        info.conv_kind = KIND_INT;
        info.conv_base = BASE_SDEC;
      end
      "o":                                    begin
        info.conv_kind = KIND_INT;
        info.conv_base = BASE_UOCT;
      end
      "u":                                    begin
        info.conv_kind = KIND_INT;
        info.conv_base = BASE_UDEC;
      end
      "x", "X":                               begin
        info.conv_kind = KIND_INT;
        info.conv_base = BASE_UHEX;
      end
      "e", "E", "f", "F", "g", "G", "a", "A": info.conv_kind = KIND_FLOAT;
      "c":                                    info.conv_kind = KIND_CHAR;
      "s":                                    info.conv_kind = KIND_STRING;
      "p":                                    info.conv_kind = KIND_POINTER;
      default:                                info.conv_ok   = 1'b0;
    endcase
    return info;
  endfunction

endpackage

[design/pft_front.sv]
// Input stage: accepts bytes, classifies them and registers the classified item.
module pft_front import pft_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] char_byte
  input  logic       in_tlast,
  output logic       fe_valid,
  output byte_info_t fe_info,
  input  logic       fe_ready
);

  logic       fe_valid_r;
  byte_info_t fe_info_r;

  assign in_tready = !fe_valid_r || fe_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fe_valid_r <= 1'b0;
    end else if (in_tready) begin
      fe_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      fe_info_r <= classify(in_tdata, in_tlast);
    end
  end

  assign fe_valid = fe_valid_r;
  assign fe_info  = fe_info_r;

endmodule

[design/pft_fifo.sv]
// Short queue of classified items between the front and the back.
module pft_fifo import pft_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push_valid,
  output logic       push_ready,
  input  byte_info_t push_info,
  output logic       pop_valid,
  input  logic       pop_ready,
  output byte_info_t pop_info
);

  localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

  byte_info_t             entry_r [FIFO_DEPTH];
  logic [PTR_W-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]       count_r, count_nxt;
  logic                   do_push, do_pop;

  assign push_ready = (count_r != CNT_W'(FIFO_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_info   = entry_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_info;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(FIFO_DEPTH))
    else $error("queue fill count beyond its depth");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (do_push && !do_pop) |=> (count_r == $past(count_r) + 1'b1))
    else $error("queue fill count did not grow on a lone push");
`endif

endmodule

[design/pft_back.sv]
// Parser back end: walks the specifier state machine and holds the result register.
module pft_back import pft_pkg::*; #(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   q_valid,
  output logic                   q_ready,
  input  byte_info_t             q_info,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // kind, base, flags, width, prec, len, char, error
  output logic                   out_tuser,  // [0] new_text_run
  output logic                   out_tlast
);

  typedef enum logic [11:0] {
    PH_TEXT      = 12'b0000_0000_0001,
    PH_FLAGS     = 12'b0000_0000_0010,
    PH_WIDTH     = 12'b0000_0000_0100,
    PH_PREC_OPEN = 12'b0000_0000_1000,
    PH_PREC      = 12'b0000_0001_0000,
    PH_LEN       = 12'b0000_0010_0000,
    PH_LEN_H     = 12'b0000_0100_0000,
    PH_LEN_L     = 12'b0000_1000_0000,
    PH_CONV      = 12'b0001_0000_0000,
    PH_SET_OPEN  = 12'b0010_0000_0000,
    PH_SET_CARET = 12'b0100_0000_0000,
    PH_SET_BODY  = 12'b1000_0000_0000
  } phase_t;

  phase_t                phase_r, phase_nxt;
  logic [5:0]            flags_r, flags_nxt;
  logic [COUNT_BITS-1:0] wc_r, wc_nxt;
  logic [COUNT_BITS-1:0] pc_r, pc_nxt;
  len_t                  len_r, len_nxt;
  logic                  run_r, run_nxt;

  logic [COUNT_BITS+3:0] wc_mul, pc_mul;
  logic [COUNT_BITS-1:0] wc_add, pc_add;
  logic [OUT_NUM_BITS-1:0] wc_out, pc_out;

  phase_t ph;
  logic   done, emit, with_fields;
  kind_t  e_kind;
  base_t  e_base;
  logic [7:0] e_char;
  logic   e_new_run;
  err_t   e_err;

  result_t res, res_r;
  logic    out_valid_r;
  logic    pop;

  assign q_ready = !out_valid_r || out_tready;
  assign pop     = q_valid && q_ready;

  // Saturating decimal accumulation: cnt*10 + digit.
  assign wc_mul = ({4'b0, wc_r} << 3) + ({4'b0, wc_r} << 1) + (COUNT_BITS + 4)'(q_info.digit);
  assign pc_mul = ({4'b0, pc_r} << 3) + ({4'b0, pc_r} << 1) + (COUNT_BITS + 4)'(q_info.digit);
  assign wc_add = (|wc_mul[COUNT_BITS+3:COUNT_BITS]) ? '1 : wc_mul[COUNT_BITS-1:0];
  assign pc_add = (|pc_mul[COUNT_BITS+3:COUNT_BITS]) ? '1 : pc_mul[COUNT_BITS-1:0];

  always_comb begin
    ph          = PH_TEXT;
    done        = 1'b0;
    emit        = 1'b0;
    with_fields = 1'b0;
    e_kind      = KIND_TEXT;
    e_base      = BASE_NONE;
    e_char      = '0;
    e_new_run   = 1'b0;
    e_err       = ERR_NONE;
    flags_nxt   = flags_r;
    wc_nxt      = wc_r;
    pc_nxt      = pc_r;
    len_nxt     = len_r;
    run_nxt     = run_r;

    case (phase_r)
      PH_TEXT, PH_FLAGS, PH_WIDTH, PH_PREC_OPEN, PH_PREC, PH_LEN, PH_LEN_H, PH_LEN_L,
      PH_CONV, PH_SET_OPEN, PH_SET_CARET, PH_SET_BODY: ph = phase_r;
      default: ph = PH_TEXT;
    endcase

    // The phases below fall through in order, so one byte may walk several of them.
    if (ph == PH_TEXT) begin
      done = 1'b1;
      if (q_info.chr == CH_PCT) begin
        flags_nxt = '0;
        wc_nxt    = '0;
        pc_nxt    = '0;
        len_nxt   = LEN_NONE;
        ph        = PH_FLAGS;
      end else begin
        emit      = 1'b1;
        e_char    = q_info.chr;
        e_new_run = !run_r;
        run_nxt   = 1'b1;
      end
    end

    if (!done && ph == PH_FLAGS) begin
      if (q_info.flag_mask != '0) begin
        flags_nxt = flags_r | {1'b0, q_info.flag_mask};
        done      = 1'b1;
      end else begin
        ph = PH_WIDTH;
        if (q_info.chr == CH_STAR) begin
          flags_nxt[FLAG_STAR] = 1'b1;
          done = 1'b1;
        end
      end
    end

    if (!done && ph == PH_WIDTH) begin
      if (q_info.is_digit) begin
        wc_nxt = wc_add;
        done   = 1'b1;
      end else if (q_info.chr == CH_DOT) begin
        ph   = PH_PREC_OPEN;
        done = 1'b1;
      end else begin
        ph = PH_LEN;
      end
    end

    if (!done && ph == PH_PREC_OPEN) begin
      if (q_info.chr == CH_STAR) begin
        flags_nxt[FLAG_STAR] = 1'b1;
        ph   = PH_LEN;
        done = 1'b1;
      end else begin
        ph = PH_PREC;
      end
    end

    if (!done && ph == PH_PREC) begin
      if (q_info.is_digit) begin
        pc_nxt = pc_add;
        done   = 1'b1;
      end else begin
        ph = PH_LEN;
      end
    end

    if (!done && ph == PH_LEN) begin
      done = 1'b1;
      case (q_info.chr)
        CH_LOW_H: begin
          len_nxt = LEN_H;
          ph      = PH_LEN_H;
        end
        CH_LOW_L: begin
          len_nxt = LEN_L;
          ph      = PH_LEN_L;
        end
        CH_UP_L: begin
          len_nxt = LEN_BIGL;
          ph      = PH_CONV;
        end
        CH_LOW_J: begin
          len_nxt = LEN_J;
          ph      = PH_CONV;
        end
        CH_LOW_T: begin
          len_nxt = LEN_T;
          ph      = PH_CONV;
        end
        default: begin
          ph   = PH_CONV;
          done = 1'b0;
        end
      endcase
    end

    if (!done && ph == PH_LEN_H) begin
      ph = PH_CONV;
      if (q_info.chr == CH_LOW_H) begin
        len_nxt = LEN_HH;
        done    = 1'b1;
      end
    end

    if (!done && ph == PH_LEN_L) begin
      ph = PH_CONV;
      if (q_info.chr == CH_LOW_L) begin
        len_nxt = LEN_LL;
        done    = 1'b1;
      end
    end

    if (!done && ph == PH_CONV) begin
      done = 1'b1;
      if (q_info.chr == CH_PCT) begin
        // A percent pair is a literal percent sign that joins any open text run.
        ph        = PH_TEXT;
        emit      = 1'b1;
        e_char    = CH_PCT;
        e_new_run = !run_r;
        run_nxt   = 1'b1;
      end else if (q_info.chr == CH_LBRK) begin
        ph = PH_SET_OPEN;
      end else if (q_info.conv_ok) begin
        ph          = PH_TEXT;
        run_nxt     = 1'b0;
        emit        = 1'b1;
        with_fields = 1'b1;
        e_kind      = q_info.conv_kind;
        e_base      = q_info.conv_base;
      end else begin
        ph      = PH_TEXT;
        run_nxt = 1'b0;
        emit    = 1'b1;
        e_kind  = KIND_ERROR;
        e_err   = ERR_BAD_LETTER;
      end
    end

    // The first member of a scanset may be ']' and does not close it.
    if (!done && ph == PH_SET_OPEN) begin
      done = 1'b1;
      ph   = (q_info.chr == CH_CARET) ? PH_SET_CARET : PH_SET_BODY;
    end

    if (!done && ph == PH_SET_CARET) begin
      done = 1'b1;
      ph   = PH_SET_BODY;
    end

    if (!done && ph == PH_SET_BODY) begin
      if (q_info.chr == CH_RBRK) begin
        ph          = PH_TEXT;
        run_nxt     = 1'b0;
        emit        = 1'b1;
        with_fields = 1'b1;
        e_kind      = KIND_SCANSET;
      end
    end

    // The last byte of a string always yields a result and returns to reset state.
    if (q_info.last && !emit) begin
      emit        = 1'b1;
      with_fields = 1'b0;
      e_kind      = KIND_ERROR;
      e_char      = '0;
      e_new_run   = 1'b0;
      e_base      = BASE_NONE;
      e_err       = (ph == PH_SET_OPEN || ph == PH_SET_CARET || ph == PH_SET_BODY) ?
                    ERR_END_SET : ERR_END_SPEC;
    end

    phase_nxt = ph;
    if (q_info.last) begin
      phase_nxt = PH_TEXT;
    end
  end

  generate
    if (COUNT_BITS > OUT_NUM_BITS) begin : g_clamp
      assign wc_out = (|wc_nxt[COUNT_BITS-1:OUT_NUM_BITS]) ? '1 : wc_nxt[OUT_NUM_BITS-1:0];
      assign pc_out = (|pc_nxt[COUNT_BITS-1:OUT_NUM_BITS]) ? '1 : pc_nxt[OUT_NUM_BITS-1:0];
    end else begin : g_extend
      assign wc_out = OUT_NUM_BITS'(wc_nxt);
      assign pc_out = OUT_NUM_BITS'(pc_nxt);
    end
  endgenerate

  always_comb begin
    res.kind      = e_kind;
    res.base      = e_base;
    res.flags     = with_fields ? flags_nxt : '0;
    res.fw        = with_fields ? wc_out : '0;
    res.prec      = with_fields ? pc_out : '0;
    res.len       = with_fields ? len_nxt : LEN_NONE;
    res.text_char = e_char;
    res.new_run   = e_new_run;
    res.err       = e_err;
    res.ends      = q_info.last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_TEXT;
      flags_r <= '0;
      wc_r    <= '0;
      pc_r    <= '0;
      len_r   <= LEN_NONE;
      run_r   <= 1'b0;
    end else if (pop) begin
      phase_r <= phase_nxt;
      if (q_info.last) begin
        flags_r <= '0;
        wc_r    <= '0;
        pc_r    <= '0;
        len_r   <= LEN_NONE;
        run_r   <= 1'b0;
      end else begin
        flags_r <= flags_nxt;
        wc_r    <= wc_nxt;
        pc_r    <= pc_nxt;
        len_r   <= len_nxt;
        run_r   <= run_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pop && emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emit) begin
      res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, res_r.err, res_r.text_char, res_r.len, res_r.prec, res_r.fw,
                       res_r.flags, res_r.base, res_r.kind};
  assign out_tuser  = res_r.new_run;
  assign out_tlast  = res_r.ends;

`ifndef SYNTHESIS
  a_last_resets: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && q_info.last) |=> (phase_r == PH_TEXT && wc_r == '0 && !run_r))
    else $error("parser state not cleared after the last byte of a string");

  a_conv_breaks_run: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && emit && e_kind != KIND_TEXT) |=> !run_r)
    else $error("text run still open after a conversion or error item");
`endif

endmodule

[design/printf_format_tokenizer.sv]
// Each byte is classified and registered, queued, then parsed into the result register.
// Throughput: one byte per cycle unless the output stalls; the parser back end consumes one queued byte
// per cycle whenever its output register is empty or being drained.
// A four-entry queue between the classifier and the parser absorbs output stalls.
// Reset (rst_n low, synchronous) empties the queue and output register and puts
// the parser in the text phase with all pending specifier fields cleared.
module printf_format_tokenizer import pft_pkg::*; #(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [7:0]             in_tdata,   // [7:0] char_byte
  input  logic                   in_tlast,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [2:0] token_kind, [5:3] number_base, [11:6] flag_bits, [27:12] width,
  // [43:28] precision_value, [46:44] length_code, [54:47] text_char, [56:55] error_code
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tuser,  // [0] new_text_run
  output logic                   out_tlast
);

  logic       fe_valid, fe_ready;
  byte_info_t fe_info;
  logic       q_valid, q_ready;
  byte_info_t q_info;

  pft_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .fe_valid  (fe_valid),
    .fe_info   (fe_info),
    .fe_ready  (fe_ready)
  );

  pft_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fe_valid),
    .push_ready (fe_ready),
    .push_info  (fe_info),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_info   (q_info)
  );

  pft_back #(
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_ready    (q_ready),
    .q_info     (q_info),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

[tb/printf_format_tokenizer_tb.sv]
// Self-checking testbench for the format string tokenizer: directed bytes, then random strings.
module printf_format_tokenizer_tb;
  import pft_pkg::*;

  localparam int CNT_BITS = COUNT_BITS_DEF;
  localparam longint unsigned CNT_MAX = (64'd1 << CNT_BITS) - 1;
  localparam int ITEMS = 500;
  localparam int QUIET_TAIL = 60;
  localparam int STALL_LIMIT = 2000;

  typedef enum logic [3:0] {
    P_TEXT, P_FLAGS, P_WIDTH, P_PREC_OPEN, P_PREC, P_LEN, P_LEN_H, P_LEN_L, P_CONV,
    P_SET_OPEN, P_SET_CARET, P_SET_BODY
  } parse_phase_t;

  typedef struct {
    logic [7:0] c;
    logic       last;
    logic       typed;
    kind_t      kind;
    logic [7:0] tch;
    logic       run;
    err_t       err;
  } probe_row_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [7:0]             in_tdata = 8'h00;
  logic                   in_tlast = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;
  logic                   out_tlast;

  printf_format_tokenizer #(.COUNT_BITS(CNT_BITS)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Parser state mirrored by the token predictor.
  parse_phase_t    phase = P_TEXT;
  logic [5:0]      pend_flags = '0;
  longint unsigned width_acc = 0;
  longint unsigned prec_acc = 0;
  len_t            pend_len = LEN_NONE;
  logic            text_open = 1'b0;

  result_t    token_q [$];
  logic [7:0] fmt_q [$];
  int         bytes_sent = 0;
  int         strings_sent = 0;
  int         tokens_seen = 0;
  int         mismatches = 0;
  int         kind_count [8];
  int         quiet_cycles = 0;
  int         stall_left = 0;
  bit         gaps_on = 1'b1;
  bit         stall_on = 1'b1;
  string      flag_chars = "#0- +";
  string      conv_set = "diouxXeEfFgGaAcsp%[";

  probe_row_t directed_rows [27] = '{
    '{8'h00, 1'b0, 1'b1, KIND_TEXT,  8'h00, 1'b1, ERR_NONE},
    '{8'hFF, 1'b0, 1'b1, KIND_TEXT,  8'hFF, 1'b0, ERR_NONE},
    // All five flags, a width past the counter range, a starred precision, ll.
    '{"%",   1'b0, 1'b0, KIND_TEXT,  8'h00, 1'b0, ERR_NONE},
    '{"#",   1'b0, 1'b0, KIND_TEXT,  8'h00, 1'b0, ERR_NONE},
    '{"0",   1'b0, 1'b0, KIND_TEXT,  8'h00, 1'b0, ERR_NONE},
    '{"-",   1'b0, 1'b0, KIND_TEXT,  8'h00, 1'b0, ERR_NONE},
    '{" ",   1'b0, 1'b0, KIND_TEXT,  8'h00, 1'b0, ERR_NONE},
    '{"+",   1'b0, 1'b0, KIND_TEXT,  8'h00, 1'b0, ERR_NONE},
    '{"9",   1'b0, 1'b0, KIND_TEXT,  8'h00, 1'b0, ERR_NONE},
    '{"9",   1'b0, 1'b0, KIND_TEXT,  8'h00, 1'b0, ERR_NONE},
    '{"9",   1'b0, 1'b0, KIND_TEXT,  8'h00, 1'b0, ERR_NONE},
    '{"9",   1'b0, 1'b0, KIND_TEXT,  8'h00, 1'b0, ERR_NONE},
    '{"9",   1'b0, 1'b0, KIND_TEXT,  8'h00, 1'b0, ERR_NONE},
    '{".",   1'b0, 1'b0, KIND_TEXT,  8'h00, 1'b0, ERR_NONE},
    '{"*",   1'b0, 1'b0, KIND_TEXT,  8'h00, 1'b0, ERR_NONE},
    '{"l",   1'b0, 1'b0, KIND_TEXT,  8'h00, 1'b0, ERR_NONE},
    '{"l",   1'b0, 1'b0, KIND_TEXT,  8'h00, 1'b0, ERR_NONE},
    '{"d",   1'b0, 1'b0, KIND_TEXT,  8'h00, 1'b0, ERR_NONE},
    // The conversion closed the text run, so this percent starts a new one.
    '{"%",   1'b0, 1'b0, KIND_TEXT,  8'h00, 1'b0, ERR_NONE},
    '{"%",   1'b0, 1'b1, KIND_TEXT,  "%",   1'b1, ERR_NONE},
    '{"%",   1'b0, 1'b0, KIND_TEXT,  8'h00, 1'b0, ERR_NONE},
    '{"q",   1'b0, 1'b1, KIND_ERROR, 8'h00, 1'b0, ERR_BAD_LETTER},
    // A bracket right after the caret is a set member, so the string ends in the set.
    '{"%",   1'b0, 1'b0, KIND_TEXT,  8'h00, 1'b0, ERR_NONE},
    '{"[",   1'b0, 1'b0, KIND_TEXT,  8'h00, 1'b0, ERR_NONE},
    '{"^",   1'b0, 1'b0, KIND_TEXT,  8'h00, 1'b0, ERR_NONE},
    '{"]",   1'b1, 1'b1, KIND_ERROR, 8'h00, 1'b0, ERR_END_SET},
    '{"%",   1'b1, 1'b1, KIND_ERROR, 8'h00, 1'b0, ERR_END_SPEC}
  };

  function automatic void clear_spec();
    pend_flags = '0;
    width_acc = 0;
    prec_acc = 0;
    pend_len = LEN_NONE;
  endfunction

  function automatic longint unsigned add_digit(longint unsigned acc, logic [7:0] c);
    longint unsigned v;
    v = acc * 10 + (c - CH_ZERO);
    return (v > CNT_MAX) ? CNT_MAX : v;
  endfunction

  function automatic logic [15:0] sat16(longint unsigned v);
    return (v > 64'hFFFF) ? 16'hFFFF : v[15:0];
  endfunction

  function automatic result_t text_token(logic [7:0] c);
    result_t t;
    t = '0;
    t.kind = KIND_TEXT;
    t.text_char = c;
    t.new_run = !text_open;
    text_open = 1'b1;
    return t;
  endfunction

  function automatic result_t spec_token(kind_t k, base_t b, bit with_fields, err_t e);
    result_t t;
    t = '0;
    t.kind = k;
    t.base = b;
    t.err = e;
    if (with_fields) begin
      t.flags = pend_flags;
      t.fw = sat16(width_acc);
      t.prec = sat16(prec_acc);
      t.len = pend_len;
    end
    return t;
  endfunction

  // Advances the mirrored parser by one byte; returns 1 when the byte yields a token.
  function automatic bit tokenize_byte(input logic [7:0] c, input logic last,
                                       output result_t tok);
    bit    got;
    bit    again;
    bit    digit;
    kind_t k;
    base_t b;
    got = 1'b0;
    tok = '0;
    digit = (c >= CH_ZERO) && (c <= CH_NINE);
    do begin
      again = 1'b0;
      case (phase)
        P_TEXT: begin
          if (c == CH_PCT) begin
            clear_spec();
            phase = P_FLAGS;
          end else begin
            tok = text_token(c);
            got = 1'b1;
          end
        end
        P_FLAGS: begin
          case (c)
            CH_HASH:  pend_flags[FLAG_ALT] = 1'b1;
            CH_ZERO:  pend_flags[FLAG_ZERO] = 1'b1;
            CH_MINUS: pend_flags[FLAG_LEFT] = 1'b1;
            CH_SPACE: pend_flags[FLAG_SPACE] = 1'b1;
            CH_PLUS:  pend_flags[FLAG_PLUS] = 1'b1;
            default: begin
              phase = P_WIDTH;
              if (c == CH_STAR) pend_flags[FLAG_STAR] = 1'b1;
              else again = 1'b1;
            end
          endcase
        end
        P_WIDTH: begin
          if (digit) width_acc = add_digit(width_acc, c);
          else if (c == CH_DOT) phase = P_PREC_OPEN;
          else begin
            phase = P_LEN;
            again = 1'b1;
          end
        end
        P_PREC_OPEN: begin
          if (c == CH_STAR) begin
            pend_flags[FLAG_STAR] = 1'b1;
            phase = P_LEN;
          end else begin
            phase = P_PREC;
            again = 1'b1;
          end
        end
        P_PREC: begin
          if (digit) prec_acc = add_digit(prec_acc, c);
          else begin
            phase = P_LEN;
            again = 1'b1;
          end
        end
        P_LEN: begin
          case (c)
            CH_LOW_H: begin
              pend_len = LEN_H;
              phase = P_LEN_H;
            end
            CH_LOW_L: begin
              pend_len = LEN_L;
              phase = P_LEN_L;
            end
            CH_UP_L: begin
              pend_len = LEN_BIGL;
              phase = P_CONV;
            end
            CH_LOW_J: begin
              pend_len = LEN_J;
              phase = P_CONV;
            end
            CH_LOW_T: begin
              pend_len = LEN_T;
              phase = P_CONV;
            end
            default: begin
              phase = P_CONV;
              again = 1'b1;
            end
          endcase
        end
        P_LEN_H: begin
          phase = P_CONV;
          if (c == CH_LOW_H) pend_len = LEN_HH;
          else again = 1'b1;
        end
        P_LEN_L: begin
          phase = P_CONV;
          if (c == CH_LOW_L) pend_len = LEN_LL;
          else again = 1'b1;
        end
        P_CONV: begin
          phase = P_TEXT;
          k = KIND_ERROR;
          b = BASE_NONE;
          case (c)
            "d", "i": begin
              k = KIND_INT;
              b = BASE_SDEC;
            end
            "o": begin
              k = KIND_INT;
              b = BASE_UOCT;
            end
            "u": begin
              k = KIND_INT;
              b = BASE_UDEC;
            end
            "x", "X": begin
              k = KIND_INT;
              b = BASE_UHEX;
            end
            "e", "E", "f", "F", "g", "G", "a", "A": k = KIND_FLOAT;
            "c": k = KIND_CHAR;
            "s": k = KIND_STRING;
            "p": k = KIND_POINTER;
            default: ;
          endcase
          if (c == CH_PCT) begin
            tok = text_token(CH_PCT);
            got = 1'b1;
          end else if (c == CH_LBRK) begin
            phase = P_SET_OPEN;
          end else begin
            text_open = 1'b0;
            tok = spec_token(k, b, k != KIND_ERROR,
                             (k == KIND_ERROR) ? ERR_BAD_LETTER : ERR_NONE);
            got = 1'b1;
          end
        end
        P_SET_OPEN: phase = (c == CH_CARET) ? P_SET_CARET : P_SET_BODY;
        P_SET_CARET: phase = P_SET_BODY;
        P_SET_BODY: begin
          if (c == CH_RBRK) begin
            phase = P_TEXT;
            text_open = 1'b0;
            tok = spec_token(KIND_SCANSET, BASE_NONE, 1'b1, ERR_NONE);
            got = 1'b1;
          end
        end
        default: begin
          phase = P_TEXT;
          again = 1'b1;
        end
      endcase
    end while (again);
    if (last) begin
      if (!got) begin
        tok = spec_token(KIND_ERROR, BASE_NONE, 1'b0,
                         (phase >= P_SET_OPEN) ? ERR_END_SET : ERR_END_SPEC);
        got = 1'b1;
      end
      tok.ends = 1'b1;
      phase = P_TEXT;
      clear_spec();
      text_open = 1'b0;
    end
    return got;
  endfunction

  // Appends one byte to the format string under construction.
  function automatic void append_char(input logic [7:0] c);
    fmt_q.insert(fmt_q.size(), c);
  endfunction

  task automatic send_byte(input logic [7:0] c, input logic last, input logic typed,
                           input result_t want);
    result_t tok;
    bit      got;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_tdata <= c;
    in_tlast <= last;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    got = tokenize_byte(c, last, tok);
    if (typed) token_q.insert(token_q.size(), want);
    else if (got) token_q.insert(token_q.size(), tok);
    bytes_sent++;
  endtask

  task automatic add_digits(int count, bit nonzero_first);
    for (int k = 0; k < count; k++)
      append_char(8'(CH_ZERO + ((k == 0 && nonzero_first) ? $urandom_range(1, 9)
                                                          : $urandom_range(0, 9))));
  endtask

  task automatic add_conversion();
    logic [7:0] letter;
    logic [7:0] member;
    append_char(CH_PCT);
    repeat ($urandom_range(0, 3)) append_char(flag_chars[$urandom_range(0, 4)]);
    // Width digits never start with zero, which would read as a flag.
    case ($urandom_range(0, 4))
      1: append_char(CH_STAR);
      2: add_digits($urandom_range(1, 3), 1'b1);
      3: add_digits($urandom_range(5, 7), 1'b1);
      4: begin
        append_char(CH_STAR);
        add_digits($urandom_range(1, 2), 1'b1);
      end
      default: ;
    endcase
    if ($urandom_range(0, 1) == 1) begin
      append_char(CH_DOT);
      case ($urandom_range(0, 3))
        1: append_char(CH_STAR);
        2: add_digits($urandom_range(1, 3), 1'b0);
        3: add_digits($urandom_range(5, 7), 1'b0);
        default: ;
      endcase
    end
    case ($urandom_range(0, 7))
      1: append_char(CH_LOW_H);
      2: begin
        append_char(CH_LOW_H);
        append_char(CH_LOW_H);
      end
      3: append_char(CH_LOW_L);
      4: begin
        append_char(CH_LOW_L);
        append_char(CH_LOW_L);
      end
      5: append_char(CH_UP_L);
      6: append_char(CH_LOW_J);
      7: append_char(CH_LOW_T);
      default: ;
    endcase
    if ($urandom_range(0, 9) == 0) letter = 8'($urandom_range(0, 255));
    else letter = conv_set[$urandom_range(0, conv_set.len() - 1)];
    append_char(letter);
    if (letter == CH_LBRK) begin
      if ($urandom_range(0, 1) == 1) append_char(CH_CARET);
      if ($urandom_range(0, 2) == 0) append_char(CH_RBRK);
      repeat ($urandom_range(0, 4)) begin
        member = 8'($urandom_range(0, 255));
        append_char((member == CH_RBRK) ? "a" : member);
      end
      append_char(CH_RBRK);
    end
  endtask

  // Builds one format string: text runs, conversions and some noise, sometimes cut short.
  task automatic compose_string();
    logic [7:0] c;
    int         start;
    fmt_q.delete();
    repeat ($urandom_range(1, 5)) begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          repeat ($urandom_range(1, 4)) begin
            c = 8'($urandom_range(0, 255));
            append_char((c == CH_PCT) ? 8'h24 : c);
          end
        end
        9: begin
          append_char(CH_PCT);
          repeat ($urandom_range(1, 2)) append_char(8'($urandom_range(0, 255)));
        end
        default: add_conversion();
      endcase
    end
    if ($urandom_range(0, 7) == 0) begin
      start = fmt_q.size();
      add_conversion();
      start = start + $urandom_range(1, fmt_q.size() - start - 1);
      while (fmt_q.size() > start) void'(fmt_q.pop_back());
    end
  endtask

  task automatic report_mismatch(string msg);
    $display("token %0d: %s", tokens_seen, msg);
    mismatches++;
  endtask

  task automatic check_field(string name, logic [63:0] got, logic [63:0] want);
    if (got !== want) report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (token_q.size() == 0) begin
        report_mismatch("result item with nothing expected");
      end else begin
        want = token_q.pop_front();
        check_field("token_kind", out_tdata[2:0], want.kind);
        check_field("number_base", out_tdata[5:3], want.base);
        check_field("flag_bits", out_tdata[11:6], want.flags);
        check_field("width", out_tdata[27:12], want.fw);
        check_field("precision_value", out_tdata[43:28], want.prec);
        check_field("length_code", out_tdata[46:44], want.len);
        check_field("text_char", out_tdata[54:47], want.text_char);
        check_field("error_code", out_tdata[56:55], want.err);
        check_field("tdata padding", out_tdata[63:57], '0);
        check_field("new_text_run", out_tuser, want.new_run);
        check_field("ends_string", out_tlast, want.ends);
      end
      kind_count[out_tdata[2:0]]++;
      tokens_seen++;
    end
  end

  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if (stall_on && $urandom_range(0, 4) == 0) begin
      stall_left <= $urandom_range(0, 8);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == STALL_LIMIT) begin
      $display("no item moved for %0d cycles", STALL_LIMIT);
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    result_t want;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      want = '0;
      want.kind = directed_rows[i].kind;
      want.text_char = directed_rows[i].tch;
      want.new_run = directed_rows[i].run;
      want.err = directed_rows[i].err;
      want.ends = directed_rows[i].last;
      send_byte(directed_rows[i].c, directed_rows[i].last, directed_rows[i].typed, want);
      if (directed_rows[i].last) strings_sent++;
    end

    while (bytes_sent < ITEMS) begin
      compose_string();
      // The tail of the run goes at full rate on both sides.
      gaps_on = (bytes_sent < ITEMS - QUIET_TAIL) && ($urandom_range(0, 3) != 0);
      stall_on = (bytes_sent < ITEMS - QUIET_TAIL) && ($urandom_range(0, 3) != 0);
      foreach (fmt_q[i]) send_byte(fmt_q[i], i == fmt_q.size() - 1, 1'b0, '0);
      strings_sent++;
    end
    in_tvalid <= 1'b0;

    while (token_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("%0d bytes in %0d format strings, %0d tokens compared, %0d mismatches",
             bytes_sent, strings_sent, tokens_seen, mismatches);
    $display("kinds: txt %0d int %0d flt %0d chr %0d str %0d ptr %0d set %0d err %0d",
             kind_count[KIND_TEXT], kind_count[KIND_INT], kind_count[KIND_FLOAT],
             kind_count[KIND_CHAR], kind_count[KIND_STRING], kind_count[KIND_POINTER],
             kind_count[KIND_SCANSET], kind_count[KIND_ERROR]);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
